// File: src/pfc_pkg.sv
// shared constants, types and register codes for the playfair digraph cipher
`default_nettype none

package pfc_pkg;

    localparam int LETTER_W    = 5;
    localparam int SIDE        = 5;
    localparam int SQUARE_SIZE = SIDE * SIDE;
    localparam int ALPHA_SIZE  = 26;
    localparam int KEY_MAX     = 24;
    localparam int KEY_HALF    = 12;
    localparam int CFG_W       = KEY_HALF * LETTER_W;
    localparam int CFG_IDX_W   = 3;
    localparam int BUILD_STEPS = KEY_MAX + ALPHA_SIZE;
    localparam int STEP_W      = $clog2(BUILD_STEPS);
    localparam int KEY_IDX_W   = $clog2(KEY_MAX);
    localparam int FILL_W      = $clog2(SQUARE_SIZE + 1);
    localparam int SEEN_W      = 1 << LETTER_W;

    typedef logic [LETTER_W-1:0] letter_t;
    typedef letter_t [SQUARE_SIZE-1:0] square_t;
    typedef logic [SIDE-1:0] side_oh_t;

    localparam letter_t PAD_LETTER   = letter_t'(25);
    localparam letter_t OMIT_DEFAULT = letter_t'(16);
    localparam letter_t LAST_LETTER  = letter_t'(ALPHA_SIZE - 1);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KEY_LOW  = 3'd0,
        CFG_KEY_HIGH = 3'd1,
        CFG_KEY_LEN  = 3'd2,
        CFG_OMIT     = 3'd3,
        CFG_DIR      = 3'd4
    } cfg_idx_t;

    typedef struct packed {
        logic built;
        logic back;
    } sq_status_t;

endpackage

`default_nettype wire

// File: src/pfc_pair_if.sv
// handshake channel carrying one letter pair
`default_nettype none

interface pfc_pair_if;
    logic                    valid;
    logic                    ready;
    pfc_pkg::letter_t        first_letter;
    pfc_pkg::letter_t        second_letter;
    logic                    has_second;

    modport source (output valid, output first_letter, output second_letter,
                    output has_second, input ready);
    modport sink   (input valid, input first_letter, input second_letter,
                    input has_second, output ready);
endinterface

`default_nettype wire

// File: src/pfc_result_if.sv
// handshake channel carrying one transformed pair
`default_nettype none

interface pfc_result_if;
    logic                    valid;
    logic                    ready;
    pfc_pkg::letter_t        out_first;
    pfc_pkg::letter_t        out_second;
    logic                    not_in_square;

    modport source (output valid, output out_first, output out_second,
                    output not_in_square, input ready);
    modport sink   (input valid, input out_first, input out_second,
                    input not_in_square, output ready);
endinterface

`default_nettype wire

// File: src/pfc_square_builder.sv
// configuration registers and the sequencer that fills the key square
`default_nettype none

module pfc_square_builder (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              wr_en,
    input  wire logic [pfc_pkg::CFG_IDX_W-1:0]     wr_index,
    input  wire logic [pfc_pkg::CFG_W-1:0]         wr_data,
    output pfc_pkg::square_t                       square,
    output pfc_pkg::sq_status_t                    status
);

    logic [pfc_pkg::CFG_W-1:0]      key_low_reg;
    logic [pfc_pkg::CFG_W-1:0]      key_high_reg;
    pfc_pkg::letter_t               key_len_reg;
    pfc_pkg::letter_t               omit_reg;
    logic                           dir_reg;
    logic                           build_reg;
    logic [pfc_pkg::STEP_W-1:0]     step_reg;
    logic [pfc_pkg::ALPHA_SIZE-1:0] seen_reg;
    logic [pfc_pkg::FILL_W-1:0]     fill_reg;
    pfc_pkg::square_t               square_reg;

    pfc_pkg::letter_t [pfc_pkg::KEY_MAX-1:0] key_arr;
    logic [pfc_pkg::SEEN_W-1:0]     seen_ext;
    pfc_pkg::letter_t               len_eff;
    pfc_pkg::letter_t               letter;
    logic                           key_phase;
    logic                           take;
    logic                           cfg_hit;

    assign key_arr  = {key_high_reg, key_low_reg};
    assign seen_ext = {{(pfc_pkg::SEEN_W - pfc_pkg::ALPHA_SIZE){1'b0}}, seen_reg};
    assign len_eff  = (key_len_reg > pfc_pkg::letter_t'(pfc_pkg::KEY_MAX))
                    ? pfc_pkg::letter_t'(pfc_pkg::KEY_MAX) : key_len_reg;
    assign key_phase = step_reg < pfc_pkg::STEP_W'(pfc_pkg::KEY_MAX);

    always_comb
    begin
        if (key_phase)
        begin
            letter = key_arr[step_reg[pfc_pkg::KEY_IDX_W-1:0]];
            take   = (pfc_pkg::letter_t'(step_reg) < len_eff)
                   && (letter <= pfc_pkg::LAST_LETTER) && !seen_ext[letter];
        end
        else
        begin
            letter = pfc_pkg::letter_t'(step_reg - pfc_pkg::STEP_W'(pfc_pkg::KEY_MAX));
            take   = (letter != omit_reg) && !seen_ext[letter];
        end
    end

    always_comb
    begin
        case (wr_index)
            pfc_pkg::CFG_KEY_LOW,
            pfc_pkg::CFG_KEY_HIGH,
            pfc_pkg::CFG_KEY_LEN,
            pfc_pkg::CFG_OMIT,
            pfc_pkg::CFG_DIR:  cfg_hit = wr_en;
            default:           cfg_hit = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_low_reg  <= '0;
            key_high_reg <= '0;
            key_len_reg  <= '0;
            omit_reg     <= pfc_pkg::OMIT_DEFAULT;
            dir_reg      <= 1'b0;
            build_reg    <= 1'b1;
            step_reg     <= '0;
            seen_reg     <= '0;
            fill_reg     <= '0;
        end
        else if (cfg_hit)
        begin
            case (wr_index)
                pfc_pkg::CFG_KEY_LOW:  key_low_reg  <= wr_data;
                pfc_pkg::CFG_KEY_HIGH: key_high_reg <= wr_data;
                pfc_pkg::CFG_KEY_LEN:  key_len_reg  <= wr_data[pfc_pkg::LETTER_W-1:0];
                pfc_pkg::CFG_OMIT:     omit_reg     <= wr_data[pfc_pkg::LETTER_W-1:0];
                pfc_pkg::CFG_DIR:      dir_reg      <= wr_data[0];
                default:               dir_reg      <= dir_reg;
            endcase
            build_reg <= 1'b1;
            step_reg  <= '0;
            seen_reg  <= '0;
            fill_reg  <= '0;
        end
        else if (build_reg)
        begin
            if (take && key_phase)
                seen_reg[letter] <= 1'b1;
            if (take && (fill_reg < pfc_pkg::FILL_W'(pfc_pkg::SQUARE_SIZE)))
                fill_reg <= fill_reg + 1'b1;
            if (step_reg == pfc_pkg::STEP_W'(pfc_pkg::BUILD_STEPS - 1))
                build_reg <= 1'b0;
            else
                step_reg <= step_reg + 1'b1;
        end
    end

    // square cells are payload, always fully rewritten before use
    always_ff @(posedge clk)
    begin
        if (build_reg && !cfg_hit && take
            && (fill_reg < pfc_pkg::FILL_W'(pfc_pkg::SQUARE_SIZE)))
            square_reg[fill_reg] <= letter;
    end

    assign square       = square_reg;
    assign status.built = !build_reg;
    assign status.back  = dir_reg;

endmodule

`default_nettype wire

// File: src/pfc_pair_core.sv
// locates both letters in the square and applies the playfair move
`default_nettype none

module pfc_pair_core (
    input  wire pfc_pkg::square_t  square,
    input  wire logic              back,
    input  wire pfc_pkg::letter_t  first_letter,
    input  wire pfc_pkg::letter_t  second_letter,
    input  wire logic              has_second,
    output pfc_pkg::letter_t       out_first,
    output pfc_pkg::letter_t       out_second,
    output logic                   not_in_square
);

    pfc_pkg::letter_t                  b;
    logic [pfc_pkg::SQUARE_SIZE-1:0]   match_a;
    logic [pfc_pkg::SQUARE_SIZE-1:0]   match_b;
    pfc_pkg::side_oh_t                 ra, ca, rb, cb;
    pfc_pkg::side_oh_t                 r1, c1, r2, c2;
    logic                              same_row, same_col;
    logic [pfc_pkg::SQUARE_SIZE-1:0]   sel_a, sel_b;
    pfc_pkg::letter_t [pfc_pkg::SQUARE_SIZE-1:0] pick_a, pick_b;
    pfc_pkg::letter_t                  res_a, res_b;

    assign b = has_second ? second_letter : pfc_pkg::PAD_LETTER;

    for (genvar k = 0; k < pfc_pkg::SQUARE_SIZE; k++)
    begin : g_cmp
        assign match_a[k] = square[k] == first_letter;
        assign match_b[k] = square[k] == b;
    end

    for (genvar i = 0; i < pfc_pkg::SIDE; i++)
    begin : g_side
        assign ra[i] = |match_a[i*pfc_pkg::SIDE +: pfc_pkg::SIDE];
        assign rb[i] = |match_b[i*pfc_pkg::SIDE +: pfc_pkg::SIDE];
        always_comb
        begin
            ca[i] = 1'b0;
            cb[i] = 1'b0;
            for (int r = 0; r < pfc_pkg::SIDE; r++)
            begin
                ca[i] = ca[i] | match_a[r*pfc_pkg::SIDE + i];
                cb[i] = cb[i] | match_b[r*pfc_pkg::SIDE + i];
            end
        end
    end

    assign same_row = |(ra & rb);
    assign same_col = |(ca & cb);

    function automatic pfc_pkg::side_oh_t rot(pfc_pkg::side_oh_t v, logic bk);
        return bk ? {v[0], v[pfc_pkg::SIDE-1:1]} : {v[pfc_pkg::SIDE-2:0], v[pfc_pkg::SIDE-1]};
    endfunction

    always_comb
    begin
        if (!same_row && !same_col)
        begin
            r1 = ra;  c1 = cb;
            r2 = rb;  c2 = ca;
        end
        else if (same_row && !same_col)
        begin
            r1 = ra;  c1 = rot(ca, back);
            r2 = rb;  c2 = rot(cb, back);
        end
        else
        begin
            // same column or identical letters
            r1 = rot(ra, back);  c1 = ca;
            r2 = rot(rb, back);  c2 = cb;
        end
    end

    for (genvar k = 0; k < pfc_pkg::SQUARE_SIZE; k++)
    begin : g_pick
        assign sel_a[k]  = r1[k / pfc_pkg::SIDE] & c1[k % pfc_pkg::SIDE];
        assign sel_b[k]  = r2[k / pfc_pkg::SIDE] & c2[k % pfc_pkg::SIDE];
        assign pick_a[k] = sel_a[k] ? square[k] : '0;
        assign pick_b[k] = sel_b[k] ? square[k] : '0;
    end

    always_comb
    begin
        res_a = '0;
        res_b = '0;
        for (int k = 0; k < pfc_pkg::SQUARE_SIZE; k++)
        begin
            res_a = res_a | pick_a[k];
            res_b = res_b | pick_b[k];
        end
    end

    assign not_in_square = !(|match_a && |match_b);
    assign out_first     = not_in_square ? first_letter : res_a;
    assign out_second    = not_in_square ? b : res_b;

endmodule

`default_nettype wire

// File: src/playfair_digraph_cipher.sv
// top level of the playfair digraph cipher: item pipeline and square builder
//
// pair carries one item per handshake: two letters (A=0 .. Z=25) and a flag
// that marks an odd tail, for which Z stands in as second letter. result
// carries the two transformed letters and a flag set when either letter is
// not in the key square, in which case both letters pass unchanged.
// An accepted item sits in the input register, passes the locate-and-move
// logic and moves into the result register once that register is free or
// result.ready is high; one item per cycle sustained while result is ready.
// The write port (wr_en, wr_index, wr_data) sets the key, its length, the
// omitted letter and the direction; writes to unused indexes are dropped.
// After reset and after every register write the square is refilled by a
// sequencer that visits 24 key slots and 26 alphabet letters, one a cycle;
// pair.ready stays low meanwhile. When result is stalled the result
// register holds and the input register still takes one more item; pair
// then waits until result.ready returns.
`default_nettype none

module playfair_digraph_cipher (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    pfc_pair_if.sink                            pair,
    pfc_result_if.source                        result,
    input  wire logic                           wr_en,
    input  wire logic [pfc_pkg::CFG_IDX_W-1:0]  wr_index,
    input  wire logic [pfc_pkg::CFG_W-1:0]      wr_data
);

    pfc_pkg::square_t     square;
    pfc_pkg::sq_status_t  status;

    logic                 s1_valid_reg;
    pfc_pkg::letter_t     s1_first_reg;
    pfc_pkg::letter_t     s1_second_reg;
    logic                 s1_has_reg;

    logic                 out_valid_reg;
    pfc_pkg::letter_t     out_first_reg;
    pfc_pkg::letter_t     out_second_reg;
    logic                 out_flag_reg;

    pfc_pkg::letter_t     core_first;
    pfc_pkg::letter_t     core_second;
    logic                 core_flag;
    logic                 advance;
    logic                 accept;

    pfc_square_builder u_builder (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .square   (square),
        .status   (status)
    );

    pfc_pair_core u_core (
        .square        (square),
        .back          (status.back),
        .first_letter  (s1_first_reg),
        .second_letter (s1_second_reg),
        .has_second    (s1_has_reg),
        .out_first     (core_first),
        .out_second    (core_second),
        .not_in_square (core_flag)
    );

    assign advance    = !out_valid_reg || result.ready;
    assign pair.ready = status.built && (!s1_valid_reg || advance);
    assign accept     = pair.valid && pair.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
                s1_valid_reg <= 1'b1;
            else if (advance)
                s1_valid_reg <= 1'b0;
            if (advance)
                out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_first_reg  <= pair.first_letter;
            s1_second_reg <= pair.second_letter;
            s1_has_reg    <= pair.has_second;
        end
        if (advance && s1_valid_reg)
        begin
            out_first_reg  <= core_first;
            out_second_reg <= core_second;
            out_flag_reg   <= core_flag;
        end
    end

    assign result.valid         = out_valid_reg;
    assign result.out_first     = out_first_reg;
    assign result.out_second    = out_second_reg;
    assign result.not_in_square = out_flag_reg;

    a_no_accept_while_building: assert property (
        @(posedge clk) disable iff (!rst_n)
        !status.built |-> !pair.ready)
        else $error("pair accepted while the key square is being filled");

    a_write_restarts_fill: assert property (
        @(posedge clk) disable iff (!rst_n)
        (wr_en && wr_index <= pfc_pkg::CFG_DIR) |=> !status.built)
        else $error("register write did not restart the square fill");

    a_stage_moves_on: assert property (
        @(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && advance) |=> out_valid_reg)
        else $error("item in input register lost on its way to the result");

    a_found_letters_in_range: assert property (
        @(posedge clk) disable iff (!rst_n)
        (result.valid && !result.not_in_square)
            |-> (result.out_first <= pfc_pkg::LAST_LETTER
                 && result.out_second <= pfc_pkg::LAST_LETTER))
        else $error("square lookup produced a letter outside the alphabet");

endmodule

`default_nettype wire
